@@ hdl/indexed_insert_remove_list_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the indexed insert/remove list
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef INDEXED_INSERT_REMOVE_LIST_TOP_MACROS_SVH
`define INDEXED_INSERT_REMOVE_LIST_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IIRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IIRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/iirl_pkg.sv @@
// ---------------------------------------------------------------------------
// Indexed insert/remove list package
// Command, status and cell operation codes, and the stage records.
// ---------------------------------------------------------------------------
package iirl_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [2:0] {
    CMD_APPEND     = 3'd0,
    CMD_INSERT     = 3'd1,
    CMD_REMOVE_END = 3'd2,
    CMD_REMOVE_AT  = 3'd3,
    CMD_READ       = 3'd4,
    CMD_WRITE      = 3'd5,
    CMD_CLEAR      = 3'd6
  } iirl_cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } iirl_status_t;

  // What the row of cells does for one decided item.
  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_WRITE = 2'd1,
    OP_INS   = 2'd2,
    OP_DEL   = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t                  kind;
    logic signed [DATA_W-1:0]  value;
  } cell_op_t;

  // Decided command, held between the control and the read stages.
  typedef struct packed {
    op_kind_t                  kind;
    logic signed [DATA_W-1:0]  value;
    logic                      rd_hit;
    logic [POS_W-1:0]          rd_pos;
    logic [COUNT_W-1:0]        count;
    iirl_status_t              status;
  } stage_t;

endpackage

@@ hdl/indexed_insert_remove_list_top.sv @@
// A result is valid after its item passes the decided, group and output stages;
// one item per cycle while no result waits. The cell row moves every shifted entry
// at once; read data passes a two-level registered select (groups of eight cells).
// Reset clears the entry count and all valid flags; entry contents are not cleared.
// in_tready is low only while a finished result waits on out_tready.
// ---------------------------------------------------------------------------
// Indexed insert/remove list
// Ordered list of signed words held in a row of cells, with insert and
// remove at a position, read, overwrite, append, remove last and clear.
// ---------------------------------------------------------------------------
module indexed_insert_remove_list_top
  import iirl_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position [5:0], value [37:6], zero [39:38]
  input  logic [2:0]  in_tuser,   // cmd [2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // read_data [31:0], count [38:32], zero [39]
  output logic [1:0]  out_tuser   // status [1:0]
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RD_N  = (DEPTH < 64) ? DEPTH : 64;
  localparam int unsigned NGRP  = (RD_N + 7) / 8;

  logic                     adv;
  logic                     accept;
  logic                     s1_valid;
  stage_t                   s1;
  logic [IDX_W-1:0]         s1_idx;
  cell_op_t                 cop;
  logic signed [DATA_W-1:0] cell_q [DEPTH];

  logic signed [DATA_W-1:0] grp_nxt [NGRP];
  logic signed [DATA_W-1:0] grp_r   [NGRP];
  logic                     s2_valid_r;
  stage_t                   s2_r;
  logic signed [DATA_W-1:0] rd_nxt;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_rd_r;
  logic [COUNT_W-1:0]       out_cnt_r;
  iirl_status_t             out_st_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign accept    = in_tvalid && adv;

  iirl_ctrl #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .adv      (adv),
    .cmd      (in_tuser),
    .position (in_tdata[5:0]),
    .value    (in_tdata[37:6]),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s1_idx   (s1_idx)
  );

  // The row only moves when the decided item moves on, so a stall never
  // applies an operation twice.
  always_comb begin
    cop.kind  = (s1_valid && adv) ? s1.kind : OP_NOP;
    cop.value = s1.value;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_w;
    logic signed [DATA_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_q[i];
    end else begin : g_mid_r
      assign right_w = cell_q[i+1];
    end
    iirl_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk     (clk),
      .op      (cop),
      .op_idx  (s1_idx),
      .left_q  (left_w),
      .right_q (right_w),
      .data_q  (cell_q[i])
    );
  end

  // First read level: one of eight cells within each group.
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      grp_nxt[g] = '0;
      for (int j = 0; j < 8; j++) begin
        if ((g * 8 + j) < RD_N) begin
          if (s1.rd_pos[2:0] == 3'(j)) grp_nxt[g] = cell_q[g*8+j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s1;
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  // Second read level: pick the group; anything but a good read gives zero.
  always_comb begin
    rd_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (s2_r.rd_hit && (s2_r.rd_pos[5:3] == 3'(g))) rd_nxt = grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r  <= s1_valid;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rd_r  <= rd_nxt;
      out_cnt_r <= s2_r.count;
      out_st_r  <= s2_r.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_rd_r};
  assign out_tuser  = out_st_r;

endmodule

@@ hdl/iirl_cell.sv @@
// ---------------------------------------------------------------------------
// List cell
// Holds one entry; overwrites, takes its left neighbour on insert or its
// right neighbour on remove, as the shared operation says.
// ---------------------------------------------------------------------------
module iirl_cell
  import iirl_pkg::*;
#(
  parameter int unsigned IDX_W = 6,
  parameter int unsigned IDX   = 0
) (
  input  logic                     clk,
  input  cell_op_t                 op,
  input  logic [IDX_W-1:0]         op_idx,
  input  logic signed [DATA_W-1:0] left_q,
  input  logic signed [DATA_W-1:0] right_q,
  output logic signed [DATA_W-1:0] data_q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (op.kind)
      OP_WRITE: begin
        if (MY_IDX == op_idx) data_nxt = op.value;
      end
      OP_INS: begin
        if (MY_IDX == op_idx) begin
          data_nxt = op.value;
        end else if (MY_IDX > op_idx) begin
          data_nxt = left_q;
        end
      end
      OP_DEL: begin
        if (MY_IDX >= op_idx) data_nxt = right_q;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

@@ hdl/iirl_ctrl.sv @@
// ---------------------------------------------------------------------------
// List control
// Holds the entry count, checks each command against it and registers the
// decided operation for the cell row and the read stage.
// ---------------------------------------------------------------------------
`include "indexed_insert_remove_list_top_macros.svh"

module iirl_ctrl
  import iirl_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic                     adv,
  input  logic [2:0]               cmd,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value,
  output logic                     s1_valid,
  output stage_t                   s1,
  output logic [IDX_W-1:0]         s1_idx
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             s1_valid_r;
  stage_t           s1_r;
  logic [IDX_W-1:0] s1_idx_r;

  op_kind_t         kind_nxt;
  iirl_status_t     st_nxt;
  logic             rd_hit_nxt;
  logic [IDX_W-1:0] idx_nxt;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic [EXT_W-1:0] cnt_ext;
  logic             empty;
  logic             full;
  logic             pos_bad;

  assign pos_x   = CMP_W'(position);
  assign cnt_x   = CMP_W'(count_r);
  assign empty   = (count_r == '0);
  assign full    = (count_r >= CNT_W'(DEPTH));
  assign pos_bad = (pos_x >= cnt_x);
  assign cnt_ext = EXT_W'(count_nxt);

  always_comb begin
    kind_nxt   = OP_NOP;
    st_nxt     = ST_OK;
    rd_hit_nxt = 1'b0;
    idx_nxt    = pos_x[IDX_W-1:0];
    count_nxt  = count_r;
    case (iirl_cmd_t'(cmd))
      CMD_APPEND: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          kind_nxt  = OP_WRITE;
          idx_nxt   = count_r[IDX_W-1:0];
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_INSERT: begin
        // An empty list takes the value as its first entry at any position.
        if (empty) begin
          kind_nxt  = OP_WRITE;
          idx_nxt   = '0;
          count_nxt = CNT_W'(1);
        end else if (pos_x > cnt_x) begin
          st_nxt = ST_BAD_INDEX;
        end else if (full) begin
          st_nxt = ST_FULL;
        end else begin
          kind_nxt  = OP_INS;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_REMOVE_END: begin
        if (empty) begin
          st_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_REMOVE_AT: begin
        if (empty) begin
          st_nxt = ST_EMPTY;
        end else if (pos_bad) begin
          st_nxt = ST_BAD_INDEX;
        end else begin
          kind_nxt  = OP_DEL;
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_READ: begin
        if (empty) begin
          st_nxt = ST_EMPTY;
        end else if (pos_bad) begin
          st_nxt = ST_BAD_INDEX;
        end else begin
          rd_hit_nxt = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (empty) begin
          st_nxt = ST_EMPTY;
        end else if (pos_bad) begin
          st_nxt = ST_BAD_INDEX;
        end else begin
          kind_nxt = OP_WRITE;
        end
      end
      CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        kind_nxt = OP_NOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) count_r <= count_nxt;
      if (adv) s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.kind   <= kind_nxt;
      s1_r.value  <= value;
      s1_r.rd_hit <= rd_hit_nxt;
      s1_r.rd_pos <= position;
      s1_r.count  <= cnt_ext[COUNT_W-1:0];
      s1_r.status <= st_nxt;
      s1_idx_r    <= idx_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;
  assign s1_idx   = s1_idx_r;

  `IIRL_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "count above depth")
  `IIRL_ASSERT_NEXT(a_clear_empties, accept && (cmd == CMD_CLEAR), count_r == '0, "clear left entries")
  `IIRL_ASSERT_NEXT(a_fail_holds, accept && (st_nxt != ST_OK), count_r == $past(count_r), "failed command changed count")
  `IIRL_ASSERT_NEXT(a_ins_grows, accept && (kind_nxt == OP_INS), count_r == $past(count_r) + 1'b1, "insert did not grow list")
  `IIRL_ASSERT_NOW(a_read_clean, s1_valid_r && s1_r.rd_hit, (s1_r.status == ST_OK) && (s1_r.kind == OP_NOP), "read hit with bad status or cell op")

endmodule
